// File: hw/rtl/tcmw_pkg.sv
// tcmw_pkg: shared types and constants for the triangle cotangent/mass weight pipeline
// no dependencies
`default_nettype none
package tcmw_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned OutW     = 48;
  // cross and dot terms: differences 33 bits, products 66, sums 67 (cross) and 68 (dot)
  localparam int unsigned DiffW    = 33;
  localparam int unsigned ProdW    = 2 * DiffW;
  localparam int unsigned CrossW   = ProdW + 1;
  localparam int unsigned DotW     = ProdW + 2;
  localparam int unsigned SqW      = 2 * CrossW + 2;
  localparam int unsigned RootW    = SqW / 2;
  localparam int unsigned MassDiv  = 1572864;
  localparam int unsigned StiffSh  = 15;

  typedef struct packed {
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [CoordW-1:0] a_z;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic signed [CoordW-1:0] b_z;
    logic signed [CoordW-1:0] c_x;
    logic signed [CoordW-1:0] c_y;
    logic signed [CoordW-1:0] c_z;
  } tri_in_t;

  typedef struct packed {
    logic [OutW-1:0]        mass_weight;
    logic signed [OutW-1:0] stiffness_weight;
    logic                   degenerate;
  } tri_out_t;

endpackage
`default_nettype wire

// File: hw/rtl/triangle_cotan_mass_weights.sv
// triangle_cotan_mass_weights: top level of the edge weight pipeline
// depends on tcmw_pkg, tcmw_isqrt, tcmw_udiv
//
//   channel   handshake          payload
//   input     start / busy       tri_in  (tcmw_pkg::tri_in_t)
//   output    done strobe        tri_out (tcmw_pkg::tri_out_t)
//
// one triangle per cycle; done rises once the item has passed through the
// 7 front stages (differences, products, cross/dot, magnitudes, square
// partial products, two adds), then 166 divide stages and 83 root stages on
// the stiffness path, then the output register
// mass path: 68 root stages and 3 stages for the divide by 24, delayed to match
// busy is tied low: nothing downstream can stall, so items simply flow
// synchronous active-high reset clears the valid bits only
`default_nettype none
module triangle_cotan_mass_weights #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire tcmw_pkg::tri_in_t  tri_in,
  output logic                    done,
  output tcmw_pkg::tri_out_t      tri_out
);
  import tcmw_pkg::*;

  localparam int unsigned NW  = DotW + StiffSh;  // shifted |dot|
  localparam int unsigned N2W = 2 * NW;          // squared
  localparam int unsigned QW  = N2W;
  localparam int unsigned QRW = QW / 2;
  // split widths for the squares: cross magnitude in two parts, |dot| in three
  localparam int unsigned LoW   = 34;
  localparam int unsigned HiW   = CrossW - LoW;
  localparam int unsigned LimbW = 28;
  localparam int unsigned TopW  = NW - 2 * LimbW;
  // delays: isqrt(S) + divide by 24 vs div(N2/S) + isqrt(q)
  localparam int unsigned LatA = RootW + 3;
  localparam int unsigned LatB = QW + QRW;
  localparam int unsigned PadA = LatB - LatA;

  assign busy = 1'b0;

  // sign-extend low COORD_WIDTH bits of each field
  function automatic logic signed [DiffW-1:0] sx(input logic [CoordW-1:0] v);
    logic [CoordW-1:0] t;
    t = v << (CoordW - COORD_WIDTH);
    return DiffW'($signed(t) >>> (CoordW - COORD_WIDTH));
  endfunction

  // stage 1: differences
  logic                    v1;
  logic signed [DiffW-1:0] ca [3];
  logic signed [DiffW-1:0] cb [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    ca[0] <= sx(tri_in.a_x) - sx(tri_in.c_x);
    ca[1] <= sx(tri_in.a_y) - sx(tri_in.c_y);
    ca[2] <= sx(tri_in.a_z) - sx(tri_in.c_z);
    cb[0] <= sx(tri_in.b_x) - sx(tri_in.c_x);
    cb[1] <= sx(tri_in.b_y) - sx(tri_in.c_y);
    cb[2] <= sx(tri_in.b_z) - sx(tri_in.c_z);
  end

  // stage 2: the nine products
  logic                    v2;
  logic signed [ProdW-1:0] pc [6];
  logic signed [ProdW-1:0] pd [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    for (int i = 0; i < 3; i++) begin
      pc[2*i]   <= ca[(i+1)%3] * cb[(i+2)%3];
      pc[2*i+1] <= ca[(i+2)%3] * cb[(i+1)%3];
      pd[i]     <= ca[i] * cb[i];
    end
  end

  // stage 3: cross components and dot
  logic                     v3;
  logic signed [CrossW-1:0] cr [3];
  logic signed [DotW-1:0]   dot3;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    for (int i = 0; i < 3; i++) begin
      cr[i] <= CrossW'(pc[2*i]) - CrossW'(pc[2*i+1]);
    end
    dot3 <= DotW'(pd[0]) + DotW'(pd[1]) + DotW'(pd[2]);
  end

  // stage 4: cross magnitudes, |dot| shifted, sign
  logic              v4;
  logic [CrossW-1:0] mc4 [3];
  logic [NW-1:0]     n4;
  logic              neg4;
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    for (int i = 0; i < 3; i++) begin
      mc4[i] <= cr[i][CrossW-1] ? CrossW'(-cr[i]) : CrossW'(cr[i]);
    end
    n4   <= NW'(dot3[DotW-1] ? DotW'(-dot3) : DotW'(dot3)) << StiffSh;
    neg4 <= dot3[DotW-1];
  end

  // stage 5: partial products of the squares, each at most 34 by 34 bits
  logic                   v5;
  logic [2*LoW-1:0]       pll [3];
  logic [HiW+LoW-1:0]     phl [3];
  logic [2*HiW-1:0]       phh [3];
  logic [2*LimbW-1:0]     n00;
  logic [2*LimbW-1:0]     n11;
  logic [2*LimbW-1:0]     n10;
  logic [TopW+LimbW-1:0]  n20;
  logic [TopW+LimbW-1:0]  n21;
  logic [2*TopW-1:0]      n22;
  logic                   neg5;
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    for (int i = 0; i < 3; i++) begin
      pll[i] <= mc4[i][LoW-1:0] * mc4[i][LoW-1:0];
      phl[i] <= mc4[i][CrossW-1:LoW] * mc4[i][LoW-1:0];
      phh[i] <= mc4[i][CrossW-1:LoW] * mc4[i][CrossW-1:LoW];
    end
    n00  <= n4[LimbW-1:0] * n4[LimbW-1:0];
    n11  <= n4[2*LimbW-1:LimbW] * n4[2*LimbW-1:LimbW];
    n10  <= n4[2*LimbW-1:LimbW] * n4[LimbW-1:0];
    n20  <= n4[NW-1:2*LimbW] * n4[LimbW-1:0];
    n21  <= n4[NW-1:2*LimbW] * n4[2*LimbW-1:LimbW];
    n22  <= n4[NW-1:2*LimbW] * n4[NW-1:2*LimbW];
    neg5 <= n4 != '0 && neg4;
  end

  // stage 6: assemble squares; the pure squares sit side by side, cross
  // terms are added doubled at their offsets
  logic                v6;
  logic [2*CrossW-1:0] sq [3];
  logic [N2W-1:0]      na6;
  logic [N2W-1:0]      nb6;
  logic                neg6;
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    for (int i = 0; i < 3; i++) begin
      sq[i] <= {phh[i], pll[i]} + ((2*CrossW)'(phl[i]) << (LoW + 1));
    end
    na6  <= {n22, n11, n00} + (N2W'(n10) << (LimbW + 1));
    nb6  <= (N2W'(n21) << (3*LimbW + 1)) + (N2W'(n20) << (2*LimbW + 1));
    neg6 <= neg5;
  end

  // stage 7: S and N^2
  logic           v7;
  logic [SqW-1:0] s7;
  logic [N2W-1:0] n27;
  logic           neg7;
  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
    s7   <= SqW'(sq[0]) + SqW'(sq[1]) + SqW'(sq[2]);
    n27  <= na6 + nb6;
    neg7 <= neg6;
  end

  // mass path: isqrt(S), then floor(root / 24) in Q16: drop 19 bits and divide
  // the remaining 48 bits by three as two 24-bit halves by reciprocal multiply
  localparam int unsigned MassSh = 19;            // MassDiv is 3 << 19
  localparam int unsigned HalfW  = OutW / 2;
  localparam int unsigned ShHi   = HalfW + 1;
  localparam int unsigned ShLo   = HalfW + 3;
  localparam logic [HalfW-1:0] RecipHi = 24'd11184811;  // (2^25 + 1) / 3
  localparam logic [HalfW+1:0] RecipLo = 26'd44739243;  // (2^27 + 1) / 3

  logic             ra_v;
  logic [RootW-1:0] ra;
  logic             ra_s;
  tcmw_isqrt #(.InW(SqW), .SideW(1)) u_root_s (
    .clk, .rst, .in_vld(v7), .radicand(s7), .in_side(s7 == '0),
    .out_vld(ra_v), .root(ra), .out_side(ra_s)
  );

  // high half times reciprocal
  logic [2*HalfW-1:0] ma_p;
  logic [HalfW-1:0]   ma_h;
  logic [HalfW-1:0]   ma_l;
  logic               ma_sat;
  logic               ma_s;
  always_ff @(posedge clk) begin
    if (ra_v) begin
      ma_p   <= ra[MassSh+OutW-1 -: HalfW] * RecipHi;
      ma_h   <= ra[MassSh+OutW-1 -: HalfW];
      ma_l   <= ra[MassSh +: HalfW];
      ma_sat <= ra[RootW-1:MassSh+OutW] != '0;
      ma_s   <= ra_s;
    end
  end

  // high quotient, its remainder joins the low half
  logic [HalfW-1:0] mb_q;
  logic [HalfW+1:0] mb_x;
  logic             mb_sat;
  logic             mb_s;
  always_ff @(posedge clk) begin
    logic [HalfW-1:0] qh;
    qh     = HalfW'(ma_p[2*HalfW-1:ShHi]);
    mb_q   <= qh;
    mb_x   <= {2'(ma_h - qh - (qh << 1)), ma_l};
    mb_sat <= ma_sat;
    mb_s   <= ma_s;
  end

  // low half times reciprocal
  logic [2*HalfW+3:0] mc_p;
  logic [HalfW-1:0]   mc_q;
  logic               mc_sat;
  logic               mc_s;
  always_ff @(posedge clk) begin
    mc_p   <= mb_x * RecipLo;
    mc_q   <= mb_q;
    mc_sat <= mb_sat;
    mc_s   <= mb_s;
  end

  logic [OutW:0] mpad [PadA+1];
  assign mpad[0] = {mc_s, mc_sat ? {OutW{1'b1}} : {mc_q, mc_p[ShLo +: HalfW]}};
  for (genvar p = 0; p < PadA; p++) begin : g_pad
    always_ff @(posedge clk) mpad[p+1] <= mpad[p];
  end

  // stiffness path: floor(N^2/S), then isqrt; S of zero is flagged and ignored
  logic           qd_v;
  logic [QW-1:0]  qd;
  logic           qd_n;
  tcmw_udiv #(.NumW(N2W), .DenW(SqW), .SideW(1)) u_stiff_div (
    .clk, .rst, .in_vld(v7), .num(n27), .den(s7), .in_side(neg7),
    .out_vld(qd_v), .quo(qd), .out_side(qd_n)
  );

  logic           qr_v;
  logic [QRW-1:0] qr;
  logic           qr_n;
  tcmw_isqrt #(.InW(QW), .SideW(1)) u_root_q (
    .clk, .rst, .in_vld(qd_v), .radicand(qd), .in_side(qd_n),
    .out_vld(qr_v), .root(qr), .out_side(qr_n)
  );

  // final saturation and output register
  always_ff @(posedge clk) begin
    logic [QRW-1:0] lim;
    logic [QRW-1:0] mg;
    lim = qr_n ? QRW'(48'h8000_0000_0000) : QRW'(48'h7FFF_FFFF_FFFF);
    mg  = (qr > lim) ? lim : qr;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= qr_v;
    end
    tri_out.mass_weight      <= mpad[PadA][OutW-1:0];
    tri_out.degenerate       <= mpad[PadA][OutW];
    tri_out.stiffness_weight <= mpad[PadA][OutW] ? '0
                              : (qr_n ? OutW'(-mg) : OutW'(mg));
  end
endmodule
`default_nettype wire

// File: hw/rtl/tcmw_isqrt.sv
// tcmw_isqrt: pipelined restoring integer square root, one result bit per stage
// no package dependency; carries a side payload alongside the operand
`default_nettype none
module tcmw_isqrt #(
  parameter int unsigned InW   = 140,
  parameter int unsigned SideW = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_vld,
  input  wire logic [InW-1:0]       radicand,
  input  wire logic [SideW-1:0]     in_side,
  output logic                      out_vld,
  output logic [InW/2-1:0]          root,
  output logic [SideW-1:0]          out_side
);
  localparam int unsigned RW = InW / 2;

  logic [RW:0]      vld;
  logic [InW-1:0]   rem [RW+1];
  logic [RW-1:0]    rt  [RW+1];
  logic [InW-1:0]   x   [RW+1];
  logic [SideW-1:0] sd  [RW+1];

  assign vld[0] = in_vld;
  assign x[0]   = radicand;
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign sd[0]  = in_side;

  // restoring digit recurrence: remainder tracks x - root^2 over the
  // consumed top bit pairs
  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [InW-1:0] rcat;
    logic [InW-1:0] trial;
    logic           take;
    assign rcat  = {rem[s][InW-3:0], x[s][InW-1 -: 2]};
    assign trial = {{(InW-RW-2){1'b0}}, rt[s], 2'b01};
    assign take  = rcat >= trial;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      rem[s+1] <= take ? rcat - trial : rcat;
      rt[s+1]  <= {rt[s][RW-2:0], take};
      x[s+1]   <= {x[s][InW-3:0], 2'b00};
      sd[s+1]  <= sd[s];
    end
  end

  assign out_vld  = vld[RW];
  assign root     = rt[RW];
  assign out_side = sd[RW];
endmodule
`default_nettype wire

// File: hw/rtl/tcmw_udiv.sv
// tcmw_udiv: pipelined restoring unsigned divider, one quotient bit per stage
// no package dependency; side payload rides along
`default_nettype none
module tcmw_udiv #(
  parameter int unsigned NumW  = 64,
  parameter int unsigned DenW  = 32,
  parameter int unsigned SideW = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_vld,
  input  wire logic [NumW-1:0]  num,
  input  wire logic [DenW-1:0]  den,
  input  wire logic [SideW-1:0] in_side,
  output logic                  out_vld,
  output logic [NumW-1:0]       quo,
  output logic [SideW-1:0]      out_side
);
  logic [NumW:0]    vld;
  logic [DenW-1:0]  rem [NumW+1];
  logic [NumW-1:0]  nm  [NumW+1];
  logic [DenW-1:0]  dn  [NumW+1];
  logic [SideW-1:0] sd  [NumW+1];

  assign vld[0] = in_vld;
  assign rem[0] = '0;
  assign nm[0]  = num;
  assign dn[0]  = den;
  assign sd[0]  = in_side;

  // numerator register shifts left; freed low bits collect quotient bits
  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic [DenW:0] rc;
    logic          take;
    assign rc   = {rem[s], nm[s][NumW-1]};
    assign take = rc >= {1'b0, dn[s]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      rem[s+1] <= take ? DenW'(rc - {1'b0, dn[s]}) : DenW'(rc);
      nm[s+1]  <= {nm[s][NumW-2:0], take};
      dn[s+1]  <= dn[s];
      sd[s+1]  <= sd[s];
    end
  end

  assign out_vld  = vld[NumW];
  assign quo      = nm[NumW];
  assign out_side = sd[NumW];
endmodule
`default_nettype wire
